// ===== hw/rtl/afd_pkg.sv =====
// ----------------------------------------------------------------------------
// ASCII frame deframer package
// Parser modes, event codes, character constants and the result record
// shared by the deframer modules.
// ----------------------------------------------------------------------------
package afd_pkg;

  localparam int DEFAULT_BUFFER_DEPTH = 256;

  typedef enum logic [1:0] {
    MODE_IDLE     = 2'd0,
    MODE_COLLECT  = 2'd1,
    MODE_WAIT_LF  = 2'd2,
    MODE_COMPLETE = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    EV_SKIPPED  = 4'd0,
    EV_START    = 4'd1,
    EV_STORED   = 4'd2,
    EV_BAD      = 4'd3,
    EV_CR       = 4'd4,
    EV_COMPLETE = 4'd5,
    EV_NO_LF    = 4'd6,
    EV_OVERFLOW = 4'd7,
    EV_IGNORED  = 4'd8
  } event_t;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UPA   = 8'h41;
  localparam logic [7:0] CH_UPF   = 8'h46;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  typedef struct packed {
    event_t     ev;
    logic [7:0] char_out;
    logic [7:0] char_index;
    logic [7:0] frame_length;
  } result_t;

endpackage

// ===== hw/rtl/afd_byte_if.sv =====
// ----------------------------------------------------------------------------
// Received byte channel
// Valid/ready channel that carries one received character per request.
// ----------------------------------------------------------------------------
interface afd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== hw/rtl/afd_event_if.sv =====
// ----------------------------------------------------------------------------
// Deframer event channel
// Valid/ready channel that carries one parser event per request.
// ----------------------------------------------------------------------------
interface afd_event_if;
  logic       valid;
  logic       ready;
  logic [3:0] event_res;
  logic [7:0] char_out;
  logic [7:0] char_index;
  logic [7:0] frame_length;

  modport source (output valid, output event_res, output char_out,
                  output char_index, output frame_length, input ready);
  modport sink   (input valid, input event_res, input char_out,
                  input char_index, input frame_length, output ready);
endinterface

// ===== hw/rtl/ascii_frame_deframer_top.sv =====
// ----------------------------------------------------------------------------
// ASCII frame deframer
// Tracks colon-started, CR LF terminated hex frames one byte at a time and
// reports one event per received byte.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Payload                                        Per request
//  rx_ch     in   rx_byte                                        one byte
//  ev_ch     out  event_res, char_out, char_index, frame_length  one event
//
// Each byte is captured in an input register, decoded against the parser
// mode and character count, and the event lands in the output register,
// from which it is offered on the event channel; a byte can be accepted every
// cycle while the event channel takes events. The mode and count update is
// a loop in the decode stage, which sets the rate at one byte per cycle.
// Reset (rst, synchronous) empties both registers, puts the parser in idle
// and clears the count. A stall on the event side holds the output register
// and backs up into the input register; bytes keep flowing until both are
// full.
module ascii_frame_deframer_top #(
  parameter int BUFFER_DEPTH = afd_pkg::DEFAULT_BUFFER_DEPTH
) (
  input logic         clk,
  input logic         rst,
  afd_byte_if.sink    rx_ch,
  afd_event_if.source ev_ch
);
  import afd_pkg::*;

  localparam int CW = $clog2(BUFFER_DEPTH);

  // Input register.
  logic       in_valid;
  logic [7:0] in_byte;

  // Parser state.
  mode_t         mode;
  mode_t         mode_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  // Output register.
  logic    out_valid;
  result_t out_res;
  result_t dec_res;

  logic out_load;

  // The output register can take a new event when it is empty or its
  // current event is being taken this cycle.
  assign out_load    = in_valid && (!out_valid || ev_ch.ready);
  assign rx_ch.ready = !in_valid || out_load;

  afd_decode #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_decode (
    .mode       (mode),
    .count      (count),
    .rx_byte    (in_byte),
    .mode_next  (mode_next),
    .count_next (count_next),
    .res        (dec_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx_ch.ready) begin
      in_valid <= rx_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_ch.ready && rx_ch.valid) begin
      in_byte <= rx_ch.rx_byte;
    end
  end

  // The parser state advances exactly when a decoded event is committed.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        mode      <= mode_next;
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (ev_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res <= dec_res;
    end
  end

  assign ev_ch.valid        = out_valid;
  assign ev_ch.event_res    = out_res.ev;
  assign ev_ch.char_out     = out_res.char_out;
  assign ev_ch.char_index   = out_res.char_index;
  assign ev_ch.frame_length = out_res.frame_length;

endmodule

// ===== hw/rtl/afd_decode.sv =====
// ----------------------------------------------------------------------------
// Deframer decode
// Classifies one character against the current parser mode and count and
// produces the event and the next mode and count.
// ----------------------------------------------------------------------------
module afd_decode #(
  parameter int BUFFER_DEPTH = afd_pkg::DEFAULT_BUFFER_DEPTH,
  localparam int CW = $clog2(BUFFER_DEPTH)
) (
  input  afd_pkg::mode_t   mode,
  input  logic [CW-1:0]    count,
  input  logic [7:0]       rx_byte,
  output afd_pkg::mode_t   mode_next,
  output logic [CW-1:0]    count_next,
  output afd_pkg::result_t res
);
  import afd_pkg::*;

  localparam logic [CW-1:0] CNT_MAX = CW'(BUFFER_DEPTH - 1);

  logic          is_hex;
  logic [CW+7:0] count_ext;

  assign is_hex = ((rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE)) ||
                  ((rx_byte >= CH_UPA) && (rx_byte <= CH_UPF));
  // Index and length are reported modulo 256 for deep buffers.
  assign count_ext = {8'b0, count};

  always_comb begin
    mode_next        = mode;
    count_next       = count;
    res.ev           = EV_SKIPPED;
    res.char_out     = '0;
    res.char_index   = '0;
    res.frame_length = '0;
    // The overflow check wins over everything, a colon included.
    if (count >= CNT_MAX) begin
      res.ev     = EV_OVERFLOW;
      mode_next  = MODE_IDLE;
      count_next = '0;
    end else if (rx_byte == CH_COLON) begin
      res.ev     = EV_START;
      mode_next  = MODE_COLLECT;
      count_next = '0;
    end else begin
      case (mode)
        MODE_IDLE: begin
          res.ev = EV_SKIPPED;
        end
        MODE_COLLECT: begin
          if (rx_byte == CH_CR) begin
            res.ev    = EV_CR;
            mode_next = MODE_WAIT_LF;
          end else if (is_hex) begin
            res.ev         = EV_STORED;
            res.char_out   = rx_byte;
            res.char_index = count_ext[7:0];
            count_next     = count + 1'b1;
          end else begin
            res.ev     = EV_BAD;
            mode_next  = MODE_IDLE;
            count_next = '0;
          end
        end
        MODE_WAIT_LF: begin
          if (rx_byte == CH_LF) begin
            res.ev           = EV_COMPLETE;
            res.frame_length = count_ext[7:0];
            mode_next        = MODE_COMPLETE;
          end else begin
            res.ev    = EV_NO_LF;
            mode_next = MODE_IDLE;
          end
          count_next = '0;
        end
        default: begin
          res.ev = EV_IGNORED;
        end
      endcase
    end
  end

endmodule
